// File: design/fpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fan PID duty controller.
// No dependencies; every other design file imports this package.
package fpd_pkg;

  localparam int TEMP_W  = 16;
  localparam int MAXT_W  = 15;
  localparam int ERR_W   = 17;
  localparam int INTEG_W = 32;
  localparam int DIFF_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int P_W     = GAIN_W + 1 + ERR_W;
  localparam int I_W     = GAIN_W + 1 + INTEG_W;
  localparam int D_W     = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W   = I_W + 1;
  localparam int FRAC_BITS = 12;

  localparam logic [7:0] DUTY_MIN = 8'd128;
  localparam logic [7:0] DUTY_MAX = 8'd255;
  localparam logic signed [SUM_W-1:0] NEG_LO = SUM_W'(128 * 4096);
  localparam logic signed [SUM_W-1:0] NEG_HI = SUM_W'(255 * 4096);

  localparam logic [MAXT_W-1:0] TARGET_RST = 15'd1392;
  localparam logic [GAIN_W-1:0] KP_RST     = 16'd5120;
  localparam logic [GAIN_W-1:0] KI_RST     = 16'd205;
  localparam logic [GAIN_W-1:0] KD_RST     = 16'd1280;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_KP     = 2'd1,
    REG_KI     = 2'd2,
    REG_KD     = 2'd3
  } fpd_reg_t;

  typedef struct packed {
    logic [MAXT_W-1:0] target;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } fpd_cfg_t;

  typedef struct packed {
    logic [MAXT_W-1:0]         max_temp;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
  } fpd_err_t;

  typedef struct packed {
    logic [MAXT_W-1:0]     max_temp;
    logic signed [P_W-1:0] p_term;
    logic signed [I_W-1:0] i_term;
    logic signed [D_W-1:0] d_term;
  } fpd_prod_t;

endpackage

// File: design/fpd_regs.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on fpd_pkg for register codes and reset values.
module fpd_regs import fpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fpd_cfg_t    cfg
);

  fpd_cfg_t cfg_r;
  fpd_reg_t sel;
  logic     wr_en;

  assign sel    = fpd_reg_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= TARGET_RST;
      cfg_r.kp     <= KP_RST;
      cfg_r.ki     <= KI_RST;
      cfg_r.kd     <= KD_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_TARGET: cfg_r.target <= pwdata[MAXT_W-1:0];
        REG_KP:     cfg_r.kp     <= pwdata[GAIN_W-1:0];
        REG_KI:     cfg_r.ki     <= pwdata[GAIN_W-1:0];
        REG_KD:     cfg_r.kd     <= pwdata[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TARGET: prdata = 32'(cfg_r.target);
      REG_KP:     prdata = 32'(cfg_r.kp);
      REG_KI:     prdata = 32'(cfg_r.ki);
      REG_KD:     prdata = 32'(cfg_r.kd);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: design/fpd_error.sv
`timescale 1ns / 1ps
// Max-temperature, error, saturating integral and difference stage; owns the loop state.
// Depends on fpd_pkg for widths and the stage payload type.
module fpd_error import fpd_pkg::*; #(
  parameter int NUM_SENSORS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  logic signed [TEMP_W-1:0] up_temps [NUM_SENSORS],
  output logic                     up_stall,
  input  logic [MAXT_W-1:0]        target,
  output logic                     dn_valid,
  output fpd_err_t                 dn_data,
  input  logic                     dn_stall
);

  logic                      valid_r;
  fpd_err_t                  data_r, data_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_r;
  logic signed [TEMP_W-1:0]  maxt;
  logic signed [INTEG_W:0]   integ_sum;
  logic                      load;

  assign up_stall = valid_r && dn_stall;
  assign load     = up_valid && !up_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    // start at zero so an all-negative set floors to zero
    maxt = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (up_temps[i] > maxt) maxt = up_temps[i];
    end
    data_nxt.max_temp = maxt[MAXT_W-1:0];
    data_nxt.err = $signed({2'b00, target}) - $signed({2'b00, maxt[MAXT_W-1:0]});
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(data_nxt.err);
    // clamp when the sign of the wide sum disagrees with the narrow one
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_nxt = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end
    data_nxt.integ = integ_nxt;
    data_nxt.diff  = DIFF_W'(data_nxt.err) - DIFF_W'(prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (!up_stall) valid_r <= up_valid;
      if (load) begin
        integ_r <= integ_nxt;
        prev_r  <= data_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= data_nxt;
  end

endmodule

// File: design/fpd_mult.sv
`timescale 1ns / 1ps
// Gain multiply stage: three parallel signed-by-unsigned products.
// Depends on fpd_pkg for the stage payload types.
module fpd_mult import fpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  fpd_err_t  up_data,
  output logic      up_stall,
  input  fpd_cfg_t  cfg,
  output logic      dn_valid,
  output fpd_prod_t dn_data,
  input  logic      dn_stall
);

  logic      valid_r;
  fpd_prod_t data_r, data_nxt;
  logic      load;

  assign up_stall = valid_r && dn_stall;
  assign load     = up_valid && !up_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.max_temp = up_data.max_temp;
    data_nxt.p_term   = $signed({1'b0, cfg.kp}) * up_data.err;
    data_nxt.i_term   = $signed({1'b0, cfg.ki}) * up_data.integ;
    data_nxt.d_term   = $signed({1'b0, cfg.kd}) * up_data.diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= data_nxt;
  end

endmodule

// File: design/fpd_duty.sv
`timescale 1ns / 1ps
// PID sum, negation and duty clamp; holds the result register.
// Depends on fpd_pkg for widths and clamp limits.
module fpd_duty import fpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  fpd_prod_t         up_data,
  output logic              up_stall,
  output logic              dn_valid,
  output logic [7:0]        dn_duty,
  output logic [MAXT_W-1:0] dn_max_temp,
  input  logic              dn_stall
);

  logic                    valid_r;
  logic [7:0]              duty_r, duty_nxt;
  logic [MAXT_W-1:0]       maxt_r;
  logic signed [SUM_W-1:0] sum, neg;
  logic                    load;

  assign up_stall    = valid_r && dn_stall;
  assign load        = up_valid && !up_stall;
  assign dn_valid    = valid_r;
  assign dn_duty     = duty_r;
  assign dn_max_temp = maxt_r;

  always_comb begin
    sum = SUM_W'(up_data.p_term) + SUM_W'(up_data.i_term) + SUM_W'(up_data.d_term);
    neg = -sum;
    if (neg <= NEG_LO) begin
      duty_nxt = DUTY_MIN;
    end else if (neg > NEG_HI) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = neg[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_r <= duty_nxt;
      maxt_r <= up_data.max_temp;
    end
  end

endmodule

// File: design/fan_pid_duty_controller.sv
`timescale 1ns / 1ps
// Fan PID duty controller: one set of sensor temperatures in, one fan duty byte
// and the floored maximum temperature out. Items transfer at one per cycle while
// the output is not stalled; a result passes in turn through the input register,
// the error and integral stage, the gain multiply stage and the clamp and result
// register. The rate is set by the integral loop, whose add-and-saturate is
// combinational ahead of its register. Stalls back up stage by stage, so empty
// stages keep taking input. Write the registers only while the pipeline is empty.
module fan_pid_duty_controller import fpd_pkg::*; #(
  parameter int NUM_SENSORS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_0,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_1,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_2,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_3,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_4,
  input  logic signed [TEMP_W-1:0] in_sensor_temp_5,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_fan_duty,
  output logic [MAXT_W-1:0]        out_max_temperature,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic signed [TEMP_W-1:0] temps_all [6];
  logic signed [TEMP_W-1:0] temps_r [NUM_SENSORS];
  logic                     in_valid_r;
  logic                     err_stall, mult_stall, duty_stall;
  logic                     err_valid, mult_valid;
  fpd_err_t                 err_data;
  fpd_prod_t                mult_data;
  fpd_cfg_t                 cfg;

  assign temps_all[0] = in_sensor_temp_0;
  assign temps_all[1] = in_sensor_temp_1;
  assign temps_all[2] = in_sensor_temp_2;
  assign temps_all[3] = in_sensor_temp_3;
  assign temps_all[4] = in_sensor_temp_4;
  assign temps_all[5] = in_sensor_temp_5;

  assign in_stall = in_valid_r && err_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // keep only the sensors in use
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      for (int i = 0; i < NUM_SENSORS; i++) temps_r[i] <= temps_all[i];
    end
  end

  fpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpd_error #(.NUM_SENSORS(NUM_SENSORS)) u_error (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_temps (temps_r),
    .up_stall (err_stall),
    .target   (cfg.target),
    .dn_valid (err_valid),
    .dn_data  (err_data),
    .dn_stall (mult_stall)
  );

  fpd_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (err_valid),
    .up_data  (err_data),
    .up_stall (mult_stall),
    .cfg      (cfg),
    .dn_valid (mult_valid),
    .dn_data  (mult_data),
    .dn_stall (duty_stall)
  );

  fpd_duty u_duty (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (mult_valid),
    .up_data     (mult_data),
    .up_stall    (duty_stall),
    .dn_valid    (out_valid),
    .dn_duty     (out_fan_duty),
    .dn_max_temp (out_max_temperature),
    .dn_stall    (out_stall)
  );

endmodule

// File: design/fpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the fan PID duty controller, bound to the top level.
// Depends on fpd_pkg for field widths.
module fpd_checker import fpd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        out_fan_duty,
  input logic [MAXT_W-1:0] out_max_temperature
);

  // duty never drops below the floor of the clamp
  a_duty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fan_duty[7])
    else $error("fan duty below clamp floor");

  // input backs up only when the whole pipeline is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side free");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_fan_duty) && $stable(out_max_temperature)))
    else $error("stalled result changed");

endmodule

bind fan_pid_duty_controller fpd_checker u_fpd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_fan_duty        (out_fan_duty),
  .out_max_temperature (out_max_temperature)
);
